// ===== rtl/b2s_pkg.sv =====
// ----------------------------------------------------------------------------
// b2s_pkg: shared types and constants for the binned 2D sum accumulator
// Bin geometry, edge table sizes, item op codes, register indexes.
// ----------------------------------------------------------------------------
package b2s_pkg;

  localparam int unsigned MaxBinsX = 64;
  localparam int unsigned MaxBinsY = 64;
  localparam int unsigned NBins    = MaxBinsX * MaxBinsY;
  localparam int unsigned XW       = $clog2(MaxBinsX + 1);   // edge index width
  localparam int unsigned YW       = $clog2(MaxBinsY + 1);
  localparam int unsigned AW       = $clog2(NBins);
  localparam int unsigned BXW      = $clog2(MaxBinsX);
  localparam int unsigned BYW      = $clog2(MaxBinsY);

  typedef enum logic [1:0] {
    OP_LOAD_E = 2'd0,
    OP_LOAD_A = 2'd1,
    OP_ADD    = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  localparam logic [0:0] REG_NBX = 1'b0;
  localparam logic [0:0] REG_NBY = 1'b1;

  // one bin record: count, three unsigned sums, signed polarization sum
  typedef struct packed {
    logic [31:0]        cnt;
    logic [47:0]        esum;
    logic [47:0]        asum;
    logic [47:0]        ssum;
    logic signed [31:0] psum;
  } bin_t;

endpackage

// ===== rtl/binned_2d_sum_accumulator.sv =====
// ----------------------------------------------------------------------------
// binned_2d_sum_accumulator: 2D histogram with per-bin saturating sums
// Edge tables loaded by items; adds search both tables with one shared
// comparator, update one bin by read-modify-write or count a miss; reads return a bin.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  in_     | in  | in_valid/in_ready  | op, wall_*, keys, values, bin_x/y
//  out_    | out | out_valid/out_ready| bin count, sums, miss count
//  cfg_    | in  | APB psel/penable   | num_bins_x, num_bins_y
//
// A load is written as it is accepted. An add first primes the comparator
// with the lowest energy edge, tests one energy bin per cycle, on a hit
// primes and scans the angle bins the same way, then does the bin
// read-modify-write in S_RD and S_UPD. Every matching energy bin reruns the
// angle scan, so overlapping energy edges stretch an add.
// A read waits in S_RESP while the output register still holds an
// unaccepted result. After reset a clearing pass writes zero to all NBins
// (4096) bin records, one per cycle, while in_ready stays low; edge tables
// and the miss counter reset directly. in_ready is low while an item is at
// work.
// ----------------------------------------------------------------------------
module binned_2d_sum_accumulator (
  input  logic               clk,
  input  logic               rst_n,
  // input items
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic [6:0]         in_wall_index,
  input  logic [31:0]        in_wall_value,
  input  logic [31:0]        in_key_energy,
  input  logic [31:0]        in_key_angle,
  input  logic [31:0]        in_energy,
  input  logic [31:0]        in_angle,
  input  logic [15:0]        in_scatter_count,
  input  logic signed [1:0]  in_polarization_value,
  input  logic [5:0]         in_bin_x,
  input  logic [5:0]         in_bin_y,
  // result items
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_hit_count,
  output logic [47:0]        out_energy_sum,
  output logic [47:0]        out_angle_sum,
  output logic [47:0]        out_scatter_sum,
  output logic signed [31:0] out_polarization_sum,
  output logic [31:0]        out_out_of_range_count,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [6:0] {
    S_CLR   = 7'b000_0001,
    S_IDLE  = 7'b000_0010,
    S_SRCHE = 7'b000_0100,  // energy edge scan
    S_SRCHA = 7'b000_1000,  // angle edge scan
    S_RD    = 7'b001_0000,  // bin read issued
    S_UPD   = 7'b010_0000,  // bin data registered, write back
    S_RESP  = 7'b100_0000   // read data registered, load output
  } state_t;

  state_t state_r, state_nxt;

  // ---- configuration registers
  logic [6:0] nbx_r, nby_r;
  logic       cfg_wr;
  logic [6:0] nbx_eff, nby_eff;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == b2s_pkg::REG_NBY) ? {25'd0, nby_r} : {25'd0, nbx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nbx_r <= 7'd64;
      nby_r <= 7'd64;
    end else if (cfg_wr) begin
      if (paddr[2] == b2s_pkg::REG_NBX) nbx_r <= pwdata[6:0];
      else                              nby_r <= pwdata[6:0];
    end
  end

  assign nbx_eff = (nbx_r > 7'(b2s_pkg::MaxBinsX)) ? 7'(b2s_pkg::MaxBinsX) : nbx_r;
  assign nby_eff = (nby_r > 7'(b2s_pkg::MaxBinsY)) ? 7'(b2s_pkg::MaxBinsY) : nby_r;

  // ---- edge tables: valid bit per entry (reset clears), data in array
  logic [31:0] e_edge_r [b2s_pkg::MaxBinsX+1];
  logic [31:0] a_edge_r [b2s_pkg::MaxBinsY+1];
  logic [b2s_pkg::MaxBinsX:0] e_vld_r;
  logic [b2s_pkg::MaxBinsY:0] a_vld_r;
  logic [31:0] e_q_r, a_q_r;             // registered edge reads at i_r / j_r

  // ---- bin memory
  b2s_pkg::bin_t bin_mem [b2s_pkg::NBins];
  b2s_pkg::bin_t bin_q_r;
  logic                    mem_we;
  logic [b2s_pkg::AW-1:0]  mem_waddr, mem_raddr;
  b2s_pkg::bin_t           mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) bin_mem[mem_waddr] <= mem_wdata;
    bin_q_r <= bin_mem[mem_raddr];
  end

  // ---- item registers
  logic [1:0]        op_r;
  logic [31:0]       ke_r, ka_r, en_r, an_r;
  logic [15:0]       sc_r;
  logic signed [1:0] pv_r;
  logic [5:0]        bx_r, by_r;
  logic [b2s_pkg::XW-1:0] i_r, i_nxt;
  logic [b2s_pkg::YW-1:0] j_r, j_nxt;
  logic [31:0]       lo_r, lo_nxt;       // lower edge of the bin under test
  logic [b2s_pkg::AW:0]   clr_r;
  logic [31:0]       miss_r;
  logic              rd_ok_r;

  // shared comparator: lo <= key < hi
  logic [31:0] cmp_key, cmp_hi;
  logic        hit;
  logic [31:0] e_rd, a_rd;

  // edge read ports follow the next index, so data lines up with i_r / j_r
  always_ff @(posedge clk) begin
    e_q_r <= e_vld_r[i_nxt] ? e_edge_r[i_nxt] : 32'd0;
    a_q_r <= a_vld_r[j_nxt] ? a_edge_r[j_nxt] : 32'd0;
  end

  assign e_rd = e_q_r;
  assign a_rd = a_q_r;
  assign cmp_key = (state_r == S_SRCHE) ? ke_r : ka_r;
  assign cmp_hi  = (state_r == S_SRCHE) ? e_rd : a_rd;
  assign hit     = (lo_r <= cmp_key) && (cmp_key < cmp_hi);

  logic accept_in;
  assign in_ready  = (state_r == S_IDLE);
  assign accept_in = in_valid && in_ready;

  // output register may be refilled in the cycle its item is taken
  logic out_valid_r;
  logic out_load;
  assign out_load = (state_r == S_RESP) && (!out_valid_r || out_ready);

  logic miss_inc;
  logic [b2s_pkg::AW-1:0] bin_addr;
  always_comb begin
    if (state_r == S_IDLE)
      bin_addr = b2s_pkg::AW'(in_bin_x * b2s_pkg::MaxBinsY + in_bin_y);
    else if (state_r == S_RESP)
      bin_addr = b2s_pkg::AW'(bx_r * b2s_pkg::MaxBinsY + by_r);
    else
      bin_addr = b2s_pkg::AW'((i_r - 1'b1) * b2s_pkg::MaxBinsY + (j_r - 1'b1));
  end
  assign mem_raddr = bin_addr;

  // saturating update
  logic [48:0] es_w, as_w, ss_w;
  logic signed [33:0] ps_w;
  always_comb begin
    es_w = {1'b0, bin_q_r.esum} + 49'(en_r);
    as_w = {1'b0, bin_q_r.asum} + 49'(an_r);
    ss_w = {1'b0, bin_q_r.ssum} + 49'(sc_r);
    ps_w = 34'(bin_q_r.psum) + 34'(pv_r);
    mem_wdata.cnt  = (&bin_q_r.cnt) ? bin_q_r.cnt : bin_q_r.cnt + 32'd1;
    mem_wdata.esum = es_w[48] ? '1 : es_w[47:0];
    mem_wdata.asum = as_w[48] ? '1 : as_w[47:0];
    mem_wdata.ssum = ss_w[48] ? '1 : ss_w[47:0];
    if (ps_w > 34'sh0_7FFF_FFFF)       mem_wdata.psum = 32'sh7FFF_FFFF;
    else if (ps_w < -34'sh0_8000_0000) mem_wdata.psum = 32'sh8000_0000;
    else                               mem_wdata.psum = ps_w[31:0];
    if (state_r == S_CLR) mem_wdata = '0;
  end
  assign mem_we    = (state_r == S_CLR) || (state_r == S_UPD);
  assign mem_waddr = (state_r == S_CLR) ? clr_r[b2s_pkg::AW-1:0] : bin_addr;

  // ---- sequencer
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    lo_nxt    = lo_r;
    miss_inc  = 1'b0;
    case (state_r)
      S_CLR: begin
        if (clr_r == b2s_pkg::NBins - 1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept_in) begin
          case (b2s_pkg::op_t'(in_op))
            b2s_pkg::OP_ADD: begin
              state_nxt = S_SRCHE;
              i_nxt     = '0;
            end
            b2s_pkg::OP_READ: state_nxt = S_RESP;
            default:          state_nxt = S_IDLE;
          endcase
        end
      end
      S_SRCHE: begin
        // i_r is the upper edge index; bin i_r-1 tested; i_r == 0 primes lo
        if (i_r == '0) begin
          i_nxt  = b2s_pkg::XW'(1);
          lo_nxt = e_rd;
        end else if (i_r > b2s_pkg::XW'(nbx_eff)) begin
          miss_inc  = 1'b1;
          state_nxt = S_IDLE;
        end else if (hit) begin
          state_nxt = S_SRCHA;
          j_nxt     = '0;
        end else begin
          i_nxt  = i_r + 1'b1;
          lo_nxt = e_rd;
        end
      end
      S_SRCHA: begin
        if (j_r == '0) begin
          j_nxt  = b2s_pkg::YW'(1);
          lo_nxt = a_rd;
        end else if (j_r > b2s_pkg::YW'(nby_eff)) begin
          // no angle bin in this energy bin: resume energy scan
          state_nxt = S_SRCHE;
          lo_nxt    = e_rd;
          i_nxt     = i_r + 1'b1;
        end else if (hit) begin
          state_nxt = S_RD;
        end else begin
          j_nxt  = j_r + 1'b1;
          lo_nxt = a_rd;
        end
      end
      S_RD:   state_nxt = S_UPD;
      S_UPD:  state_nxt = S_IDLE;
      S_RESP: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      miss_r  <= '0;
      e_vld_r <= '0;
      a_vld_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) clr_r <= clr_r + 1'b1;
      if (miss_inc && !(&miss_r)) miss_r <= miss_r + 32'd1;
      if (accept_in && in_op == b2s_pkg::OP_LOAD_E &&
          in_wall_index <= 7'(b2s_pkg::MaxBinsX))
        e_vld_r[in_wall_index[b2s_pkg::XW-1:0]] <= 1'b1;
      if (accept_in && in_op == b2s_pkg::OP_LOAD_A &&
          in_wall_index <= 7'(b2s_pkg::MaxBinsY))
        a_vld_r[in_wall_index[b2s_pkg::YW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    i_r  <= i_nxt;
    j_r  <= j_nxt;
    lo_r <= lo_nxt;
    if (accept_in) begin
      op_r    <= in_op;
      ke_r    <= in_key_energy;
      ka_r    <= in_key_angle;
      en_r    <= in_energy;
      an_r    <= in_angle;
      sc_r    <= in_scatter_count;
      pv_r    <= in_polarization_value;
      bx_r    <= in_bin_x;
      by_r    <= in_bin_y;
      rd_ok_r <= (7'(in_bin_x) < nbx_eff) && (7'(in_bin_y) < nby_eff);
      if (in_op == b2s_pkg::OP_LOAD_E && in_wall_index <= 7'(b2s_pkg::MaxBinsX))
        e_edge_r[in_wall_index[b2s_pkg::XW-1:0]] <= in_wall_value;
      if (in_op == b2s_pkg::OP_LOAD_A && in_wall_index <= 7'(b2s_pkg::MaxBinsY))
        a_edge_r[in_wall_index[b2s_pkg::YW-1:0]] <= in_wall_value;
    end
  end

  // ---- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hit_count          <= rd_ok_r ? bin_q_r.cnt  : '0;
      out_energy_sum         <= rd_ok_r ? bin_q_r.esum : '0;
      out_angle_sum          <= rd_ok_r ? bin_q_r.asum : '0;
      out_scatter_sum        <= rd_ok_r ? bin_q_r.ssum : '0;
      out_polarization_sum   <= rd_ok_r ? bin_q_r.psum : '0;
      out_out_of_range_count <= miss_r;
    end
  end
  assign out_valid = out_valid_r;

  // ---- assertions
  a_no_in_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("in_ready while busy");
  a_out_only_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> (op_r == b2s_pkg::OP_READ)) else $error("result from non-read");
  a_upd_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> $past(state_r == S_RD)) else $error("write without read");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_hit_count))
    else $error("result dropped");

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for binned_2d_sum_accumulator
// Loads edge tables, adds samples and reads bins back under random idling
// on both channels. A bench-side histogram model predicts every read result
// and the checker compares each field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  // covers the clear pass and an add over overlapping edges
  localparam int unsigned WatchdogLimit = 20000;
  localparam logic [47:0] Max48 = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    b2s_pkg::op_t op;
    logic [6:0]  widx;
    logic [31:0] wval;
    logic [31:0] key_e;
    logic [31:0] key_a;
    logic [31:0] energy;
    logic [31:0] angle;
    logic [15:0] scatter;
    logic [1:0]  pol;
    logic [5:0]  bx;
    logic [5:0]  by;
  } item_t;

  typedef struct {
    logic [31:0] hits;
    logic [47:0] esum;
    logic [47:0] asum;
    logic [47:0] ssum;
    logic [31:0] psum;
    logic [31:0] misses;
  } bin_read_t;

  logic clk, rst_n;
  logic in_valid, in_ready;
  logic [1:0] in_op;
  logic [6:0] in_wall_index;
  logic [31:0] in_wall_value, in_key_energy, in_key_angle, in_energy, in_angle;
  logic [15:0] in_scatter_count;
  logic signed [1:0] in_polarization_value;
  logic [5:0] in_bin_x, in_bin_y;
  logic out_valid, out_ready;
  logic [31:0] out_hit_count;
  logic [47:0] out_energy_sum, out_angle_sum, out_scatter_sum;
  logic signed [31:0] out_polarization_sum;
  logic [31:0] out_out_of_range_count;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  binned_2d_sum_accumulator u_dut (.*);

  // ---- histogram model kept by the bench ----
  logic [6:0]  nbx_reg, nby_reg;
  logic [31:0] e_edge [b2s_pkg::MaxBinsX+1];
  logic [31:0] a_edge [b2s_pkg::MaxBinsY+1];
  logic [31:0] hits_m [b2s_pkg::NBins];
  logic [47:0] esum_m [b2s_pkg::NBins];
  logic [47:0] asum_m [b2s_pkg::NBins];
  logic [47:0] ssum_m [b2s_pkg::NBins];
  int          psum_m [b2s_pkg::NBins];
  logic [31:0] miss_m;

  bin_read_t pending_reads[$];
  int errors;
  bit no_gaps;          // stretches with no idling on either side
  int hold_cycles;      // receiver long hold-off request
  int idle_cnt;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [47:0] sat48(logic [47:0] a, logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + b;
    return s > {1'b0, Max48} ? Max48 : s[47:0];
  endfunction

  function automatic logic [31:0] inc32(logic [31:0] a);
    return &a ? a : a + 32'd1;
  endfunction

  function automatic int unsigned used_x();
    return nbx_reg > b2s_pkg::MaxBinsX ? b2s_pkg::MaxBinsX : nbx_reg;
  endfunction

  function automatic int unsigned used_y();
    return nby_reg > b2s_pkg::MaxBinsY ? b2s_pkg::MaxBinsY : nby_reg;
  endfunction

  // update the histogram for one accepted item; reads queue their result
  function automatic void histogram_apply(item_t it);
    int unsigned b;
    longint p;
    bit placed;
    bin_read_t r;
    placed = 0;
    case (it.op)
      b2s_pkg::OP_LOAD_E: if (it.widx <= b2s_pkg::MaxBinsX) e_edge[it.widx] = it.wval;
      b2s_pkg::OP_LOAD_A: if (it.widx <= b2s_pkg::MaxBinsY) a_edge[it.widx] = it.wval;
      b2s_pkg::OP_ADD: begin
        for (int i = 0; i < used_x() && !placed; i++) begin
          if (e_edge[i] <= it.key_e && it.key_e < e_edge[i+1]) begin
            for (int j = 0; j < used_y() && !placed; j++) begin
              if (a_edge[j] <= it.key_a && it.key_a < a_edge[j+1]) begin
                b = i * b2s_pkg::MaxBinsY + j;
                p = longint'(psum_m[b]) + longint'($signed(it.pol));
                if (p > 64'sd2147483647) p = 64'sd2147483647;
                if (p < -64'sd2147483648) p = -64'sd2147483648;
                hits_m[b] = inc32(hits_m[b]);
                esum_m[b] = sat48(esum_m[b], it.energy);
                asum_m[b] = sat48(asum_m[b], it.angle);
                ssum_m[b] = sat48(ssum_m[b], {16'd0, it.scatter});
                psum_m[b] = int'(p);
                placed = 1;
              end
            end
          end
        end
        if (!placed) miss_m = inc32(miss_m);
      end
      default: begin
        r = '{default: '0};
        if (it.bx < used_x() && it.by < used_y()) begin
          b = it.bx * b2s_pkg::MaxBinsY + it.by;
          r.hits = hits_m[b];
          r.esum = esum_m[b];
          r.asum = asum_m[b];
          r.ssum = ssum_m[b];
          r.psum = psum_m[b];
        end
        r.misses = miss_m;
        pending_reads.push_back(r);
      end
    endcase
  endfunction

  // ---- sender ----
  function automatic item_t rand_item(b2s_pkg::op_t op);
    item_t it;
    it.op      = op;
    it.widx    = 7'($urandom);
    it.wval    = $urandom;
    it.key_e   = $urandom;
    it.key_a   = $urandom;
    it.energy  = $urandom;
    it.angle   = $urandom;
    it.scatter = 16'($urandom);
    it.pol     = 2'($urandom);
    it.bx      = 6'($urandom);
    it.by      = 6'($urandom);
    return it;
  endfunction

  task automatic send_item(item_t it);
    int r, gap;
    @(negedge clk);
    in_valid              = 1'b1;
    in_op                 = it.op;
    in_wall_index         = it.widx;
    in_wall_value         = it.wval;
    in_key_energy         = it.key_e;
    in_key_angle          = it.key_a;
    in_energy             = it.energy;
    in_angle              = it.angle;
    in_scatter_count      = it.scatter;
    in_polarization_value = it.pol;
    in_bin_x              = it.bx;
    in_bin_y              = it.by;
    do @(posedge clk); while (!in_ready);
    histogram_apply(it);
    // gap after the item: mostly none or short, now and then long
    r = $urandom_range(0, 99);
    gap = no_gaps ? 0 : r < 70 ? 0 : r < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // drain: all reads back and the last item finished
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_reads.size() != 0 || !in_ready) @(negedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == b2s_pkg::REG_NBX) nbx_reg = val[6:0];
    else nby_reg = val[6:0];
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic set_bins(int nx, int ny);
    wait_idle();
    write_reg(b2s_pkg::REG_NBX, nx);
    write_reg(b2s_pkg::REG_NBY, ny);
  endtask

  // ascending edges over both whole tables; step stays small enough not to wrap
  task automatic load_ramp(int unsigned max_step);
    logic [31:0] v;
    item_t it;
    v = $urandom_range(0, 1000);
    for (int i = 0; i <= b2s_pkg::MaxBinsX; i++) begin
      it = rand_item(b2s_pkg::OP_LOAD_E); it.widx = 7'(i); it.wval = v; send_item(it);
      v += $urandom_range(1, max_step);
    end
    v = $urandom_range(0, 1000);
    for (int i = 0; i <= b2s_pkg::MaxBinsY; i++) begin
      it = rand_item(b2s_pkg::OP_LOAD_A); it.widx = 7'(i); it.wval = v; send_item(it);
      v += $urandom_range(1, max_step);
    end
  endtask

  // a key inside the active edge span most of the time, a bit past it sometimes
  function automatic logic [31:0] key_in(logic [31:0] lo, logic [31:0] hi);
    if ($urandom_range(0, 9) == 0) return $urandom;
    if (hi <= lo) return lo;
    return lo + $urandom_range(0, hi - lo + (hi - lo) / 16);
  endfunction

  // ---- receiver ----
  always @(negedge clk) begin
    int r;
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (no_gaps) begin
      out_ready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      out_ready <= r >= 20;
      if (r == 0) hold_cycles <= $urandom_range(10, 50);
    end
  end

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    bin_read_t w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reads.size() == 0) begin
        report("unexpected result", out_hit_count, 0);
      end else begin
        w = pending_reads.pop_front();
        if (out_hit_count !== w.hits) report("hit_count", out_hit_count, w.hits);
        if (out_energy_sum !== w.esum) report("energy_sum", out_energy_sum, w.esum);
        if (out_angle_sum !== w.asum) report("angle_sum", out_angle_sum, w.asum);
        if (out_scatter_sum !== w.ssum) report("scatter_sum", out_scatter_sum, w.ssum);
        if (out_polarization_sum !== w.psum)
          report("polarization_sum", out_polarization_sum, w.psum);
        if (out_out_of_range_count !== w.misses)
          report("out_of_range_count", out_out_of_range_count, w.misses);
      end
    end
  end

  // watchdog: consecutive cycles with no handshake on any port
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pwrite && pready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WatchdogLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // ---- tests ----
  task automatic test_reset_state();
    item_t it;
    // zero edges: nothing fits, so an add is a miss
    it = rand_item(b2s_pkg::OP_ADD); send_item(it);
    it = rand_item(b2s_pkg::OP_READ); it.bx = 0; it.by = 0; send_item(it);
    it = rand_item(b2s_pkg::OP_READ); it.bx = 63; it.by = 63; send_item(it);
  endtask

  task automatic test_directed();
    item_t it;
    set_bins(4, 4);
    load_ramp(1 << 20);
    // key exactly on a lower edge, polarization codes incl. minus two
    for (int c = 0; c < 4; c++) begin
      it = rand_item(b2s_pkg::OP_ADD);
      it.key_e = e_edge[1]; it.key_a = a_edge[2]; it.pol = 2'(c);
      it.energy = 32'hFFFF_FFFF; it.angle = 32'hFFFF_FFFF; it.scatter = 16'hFFFF;
      send_item(it);
    end
    // key on the top edge of the last bin: miss
    it = rand_item(b2s_pkg::OP_ADD); it.key_e = e_edge[4]; it.key_a = a_edge[0];
    send_item(it);
    it = rand_item(b2s_pkg::OP_ADD); it.key_e = e_edge[0]; it.key_a = a_edge[0];
    it.energy = 0; it.angle = 0; it.scatter = 0; send_item(it);
    // loads past the table end are dropped
    it = rand_item(b2s_pkg::OP_LOAD_E); it.widx = 65; send_item(it);
    it = rand_item(b2s_pkg::OP_LOAD_A); it.widx = 127; send_item(it);
    it = rand_item(b2s_pkg::OP_READ); it.bx = 1; it.by = 2; send_item(it);
    it = rand_item(b2s_pkg::OP_READ); it.bx = 0; it.by = 0; send_item(it);
    it = rand_item(b2s_pkg::OP_READ); it.bx = 4; it.by = 0; send_item(it);  // outside in use
    it = rand_item(b2s_pkg::OP_READ); it.bx = 63; it.by = 63; send_item(it);
    // no bins at all
    set_bins(0, 0);
    it = rand_item(b2s_pkg::OP_ADD); it.key_e = e_edge[0]; it.key_a = a_edge[0];
    send_item(it);
    it = rand_item(b2s_pkg::OP_READ); it.bx = 0; it.by = 0; send_item(it);
    // register above maximum clamps to 64
    set_bins(127, 65);
    it = rand_item(b2s_pkg::OP_ADD); it.key_e = e_edge[63]; it.key_a = a_edge[63];
    send_item(it);
    it = rand_item(b2s_pkg::OP_READ); it.bx = 63; it.by = 63; send_item(it);
  endtask

  task automatic test_random(int nx, int ny, int count);
    item_t it;
    int r;
    set_bins(nx, ny);
    load_ramp($urandom_range(0, 1) ? (1 << 25) : 1000);
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        it = rand_item(b2s_pkg::OP_ADD);
        it.key_e = key_in(e_edge[0], e_edge[used_x()]);
        it.key_a = key_in(a_edge[0], a_edge[used_y()]);
      end else if (r < 90) begin
        it = rand_item(b2s_pkg::OP_READ);
        if (used_x() > 0 && $urandom_range(0, 3) != 0)
          it.bx = 6'($urandom_range(0, used_x() - 1));
        if (used_y() > 0 && $urandom_range(0, 3) != 0)
          it.by = 6'($urandom_range(0, used_y() - 1));
      end else begin
        // noise: random loads may break the ascending order
        it = rand_item(b2s_pkg::op_t'($urandom_range(0, 1)));
      end
      send_item(it);
    end
  endtask

  task automatic test_backpressure();
    item_t it;
    wait_idle();
    @(posedge clk);
    hold_cycles = 400;
    for (int n = 0; n < 20; n++) begin
      it = rand_item(b2s_pkg::OP_READ); send_item(it);
    end
  endtask

  initial begin
    errors = 0; no_gaps = 0; hold_cycles = 0; idle_cnt = 0;
    rst_n = 1'b0; in_valid = 1'b0; out_ready = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_op = '0; in_wall_index = '0; in_wall_value = '0; in_key_energy = '0;
    in_key_angle = '0; in_energy = '0; in_angle = '0; in_scatter_count = '0;
    in_polarization_value = '0; in_bin_x = '0; in_bin_y = '0;
    nbx_reg = 7'd64; nby_reg = 7'd64; miss_m = '0;
    foreach (e_edge[i]) e_edge[i] = '0;
    foreach (a_edge[i]) a_edge[i] = '0;
    for (int b = 0; b < b2s_pkg::NBins; b++) begin
      hits_m[b] = '0; esum_m[b] = '0; asum_m[b] = '0; ssum_m[b] = '0; psum_m[b] = 0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_directed();
    test_random(4, 4, 150);
    no_gaps = 1;
    test_random(1, 1, 60);
    no_gaps = 0;
    test_random(8, 3, 150);
    test_random(2, 64, 100);
    test_random(64, 64, 60);
    test_backpressure();
    test_random(5, 5, 60);

    wait_idle();
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
